/* rtl/block_mean_pixelate_macros.svh */
// Assertion macros for the block_mean_pixelate design.
// Each macro expects signals named clk and rst in the scope where it is used.
`ifndef BLOCK_MEAN_PIXELATE_MACROS_SVH
`define BLOCK_MEAN_PIXELATE_MACROS_SVH

`ifndef SYNTHESIS

// Same-cycle implication, checked at every rising edge outside reset.
`define BMP_ASSERT_IMPLY(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, checked at every rising edge outside reset.
`define BMP_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`else

`define BMP_ASSERT_IMPLY(lbl, ante, cons, msg)
`define BMP_ASSERT_NEXT(lbl, ante, cons, msg)

`endif

`endif

/* rtl/bmp_pkg.sv */
`timescale 1ns / 1ps

package bmp_pkg;

  // Widths fixed by the field and register definitions.
  localparam int unsigned CHAN_W   = 8;
  localparam int unsigned POS_W    = 12;
  localparam int unsigned EXT_W    = 13;
  localparam int unsigned SIDE_W   = 7;
  localparam int unsigned SUM_W    = 20;
  localparam int unsigned TALLY_W  = 13;
  localparam int unsigned STEP_W   = $clog2(SUM_W);
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned CFG_DAT_W = 13;

  localparam int unsigned IN_TDATA_W  = 32;
  localparam int unsigned OUT_TDATA_W = 72;

  // Default sizing.
  localparam int unsigned MAX_BLOCKS_ACROSS_DEF = 256;
  localparam int unsigned MAX_BLOCK_SIDE_DEF    = 64;
  localparam int unsigned QUEUE_DEPTH           = 4;

  // Frame extent limit and reset values.
  localparam logic [EXT_W-1:0]  FRAME_MAX       = 13'd4096;
  localparam logic [EXT_W-1:0]  WIDTH_RESET     = 13'd640;
  localparam logic [EXT_W-1:0]  HEIGHT_RESET    = 13'd480;
  localparam logic [SIDE_W-1:0] BLOCK_RESET     = 7'd10;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_BLOCK_SIZE   = 2'd2;

  // One classified pixel on its way from the front end to the accumulator.
  typedef struct packed {
    logic [CHAN_W-1:0] red;
    logic [CHAN_W-1:0] green;
    logic [CHAN_W-1:0] blue;
    logic [CHAN_W-1:0] alpha;
    logic              first;
    logic              last;
    logic [POS_W-1:0]  col;
    logic [POS_W-1:0]  row;
    logic [SIDE_W-1:0] cw;
    logic [SIDE_W-1:0] ch;
  } bmp_item_t;

  // One accumulator memory word.
  typedef struct packed {
    logic [SUM_W-1:0]   red;
    logic [SUM_W-1:0]   green;
    logic [SUM_W-1:0]   blue;
    logic [SUM_W-1:0]   alpha;
    logic [TALLY_W-1:0] tally;
  } bmp_acc_t;

  // One finished block.
  typedef struct packed {
    logic [POS_W-1:0]  block_col;
    logic [POS_W-1:0]  block_row;
    logic [CHAN_W-1:0] mean_red;
    logic [CHAN_W-1:0] mean_green;
    logic [CHAN_W-1:0] mean_blue;
    logic [CHAN_W-1:0] mean_alpha;
    logic [SIDE_W-1:0] clip_width;
    logic [SIDE_W-1:0] clip_height;
  } bmp_result_t;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_ACC,
    BK_DIV,
    BK_DONE
  } bmp_back_state_t;

  // Zero acts as one, and anything above the frame limit saturates.
  function automatic logic [EXT_W-1:0] clamp_extent(input logic [EXT_W-1:0] v);
    logic [EXT_W-1:0] r;
    if (v == '0) begin
      r = 13'd1;
    end else if (v > FRAME_MAX) begin
      r = FRAME_MAX;
    end else begin
      r = v;
    end
    return r;
  endfunction

endpackage

/* rtl/bmp_ram.sv */
`timescale 1ns / 1ps

module bmp_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

/* rtl/bmp_fifo.sv */
`timescale 1ns / 1ps

module bmp_fifo #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 4,
  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] push_data,
  input  logic             pop,
  output logic [WIDTH-1:0] head,
  output logic             full,
  output logic             empty
);

  logic [WIDTH-1:0] slots [DEPTH];
  logic [PW-1:0]    wr_ptr;
  logic [PW-1:0]    rd_ptr;
  logic [PW:0]      count;

  assign full  = (count == (PW+1)'(DEPTH));
  assign empty = (count == '0);
  assign head  = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_data;
    end
  end

endmodule

/* rtl/bmp_front.sv */
`timescale 1ns / 1ps

module bmp_front
  import bmp_pkg::*;
#(
  parameter int unsigned MAX_BLOCKS_ACROSS = MAX_BLOCKS_ACROSS_DEF,
  parameter int unsigned MAX_BLOCK_SIDE    = MAX_BLOCK_SIDE_DEF,
  localparam int unsigned SLOT_W = (MAX_BLOCKS_ACROSS > 1) ? $clog2(MAX_BLOCKS_ACROSS) : 1
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_DAT_W-1:0] cfg_data,
  input  logic                 pix_valid,
  input  logic [CHAN_W-1:0]    pix_red,
  input  logic [CHAN_W-1:0]    pix_green,
  input  logic [CHAN_W-1:0]    pix_blue,
  input  logic [CHAN_W-1:0]    pix_alpha,
  input  logic                 queue_full,
  output logic                 pix_ready,
  output logic                 push,
  output bmp_item_t            push_item,
  output logic [SLOT_W-1:0]    push_slot
);

  logic [EXT_W-1:0]  frame_w;
  logic [EXT_W-1:0]  frame_h;
  logic [SIDE_W-1:0] side;
  logic [POS_W-1:0]  x_pos;
  logic [POS_W-1:0]  y_pos;
  logic [SIDE_W-1:0] x_in;
  logic [SIDE_W-1:0] y_in;
  logic [POS_W-1:0]  col;
  logic [POS_W-1:0]  row;
  logic [POS_W-1:0]  col_start;
  logic [POS_W-1:0]  row_start;
  logic [SLOT_W-1:0] slot;

  logic [EXT_W-1:0]  rem_w;
  logic [EXT_W-1:0]  rem_h;
  logic [SIDE_W-1:0] cw;
  logic [SIDE_W-1:0] ch;
  logic [SIDE_W:0]   x_in_inc;
  logic [SIDE_W:0]   y_in_inc;
  logic              x_wrap;
  logic              y_wrap;
  logic              row_end;
  logic              frame_end;
  logic              cfg_hit;
  logic [SIDE_W-1:0] side_clamped;

  // Nothing is taken while reset is held.
  assign cfg_ready = !rst;
  assign pix_ready = !rst && !queue_full;
  assign push      = pix_valid && pix_ready;

  // Clipped block extent: the block side, or what is left of the frame.
  assign rem_w = frame_w - {1'b0, col_start};
  assign rem_h = frame_h - {1'b0, row_start};
  assign cw    = (rem_w < {{(EXT_W-SIDE_W){1'b0}}, side}) ? rem_w[SIDE_W-1:0] : side;
  assign ch    = (rem_h < {{(EXT_W-SIDE_W){1'b0}}, side}) ? rem_h[SIDE_W-1:0] : side;

  assign x_in_inc  = {1'b0, x_in} + 1'b1;
  assign y_in_inc  = {1'b0, y_in} + 1'b1;
  assign x_wrap    = (x_in_inc >= {1'b0, side});
  assign y_wrap    = (y_in_inc >= {1'b0, side});
  assign row_end   = ({1'b0, x_pos} + 1'b1 >= frame_w);
  assign frame_end = ({1'b0, y_pos} + 1'b1 >= frame_h);

  always_comb begin
    push_item.red   = pix_red;
    push_item.green = pix_green;
    push_item.blue  = pix_blue;
    push_item.alpha = pix_alpha;
    push_item.first = (x_in == '0) && (y_in == '0);
    push_item.last  = (x_in_inc == {1'b0, cw}) && (y_in_inc == {1'b0, ch});
    push_item.col   = col;
    push_item.row   = row;
    push_item.cw    = cw;
    push_item.ch    = ch;
    push_slot       = slot;
  end

  always_comb begin
    if (cfg_data[SIDE_W-1:0] == '0) begin
      side_clamped = 7'd1;
    end else if ({2'b00, cfg_data[SIDE_W-1:0]} > 9'(MAX_BLOCK_SIDE)) begin
      side_clamped = SIDE_W'(MAX_BLOCK_SIDE);
    end else begin
      side_clamped = cfg_data[SIDE_W-1:0];
    end
  end

  assign cfg_hit = cfg_valid && (cfg_index == REG_FRAME_WIDTH ||
                   cfg_index == REG_FRAME_HEIGHT || cfg_index == REG_BLOCK_SIZE);

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_w <= WIDTH_RESET;
      frame_h <= HEIGHT_RESET;
      side    <= BLOCK_RESET;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_FRAME_WIDTH:  frame_w <= clamp_extent(cfg_data);
        REG_FRAME_HEIGHT: frame_h <= clamp_extent(cfg_data);
        REG_BLOCK_SIZE:   side    <= side_clamped;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst || cfg_hit) begin
      x_pos     <= '0;
      y_pos     <= '0;
      x_in      <= '0;
      y_in      <= '0;
      col       <= '0;
      row       <= '0;
      col_start <= '0;
      row_start <= '0;
      slot      <= '0;
    end else if (push) begin
      if (row_end) begin
        x_pos     <= '0;
        x_in      <= '0;
        col       <= '0;
        col_start <= '0;
        slot      <= '0;
        if (frame_end) begin
          y_pos     <= '0;
          y_in      <= '0;
          row       <= '0;
          row_start <= '0;
        end else begin
          y_pos <= y_pos + 1'b1;
          if (y_wrap) begin
            y_in      <= '0;
            row       <= row + 1'b1;
            row_start <= y_pos + 1'b1;
          end else begin
            y_in <= y_in_inc[SIDE_W-1:0];
          end
        end
      end else begin
        x_pos <= x_pos + 1'b1;
        if (x_wrap) begin
          x_in      <= '0;
          col       <= col + 1'b1;
          col_start <= x_pos + 1'b1;
          slot      <= (slot == SLOT_W'(MAX_BLOCKS_ACROSS - 1)) ? '0 : slot + 1'b1;
        end else begin
          x_in <= x_in_inc[SIDE_W-1:0];
        end
      end
    end
  end

endmodule

/* rtl/bmp_back.sv */
`timescale 1ns / 1ps
`include "block_mean_pixelate_macros.svh"

module bmp_back
  import bmp_pkg::*;
#(
  parameter int unsigned MAX_BLOCKS_ACROSS = MAX_BLOCKS_ACROSS_DEF,
  localparam int unsigned SLOT_W = (MAX_BLOCKS_ACROSS > 1) ? $clog2(MAX_BLOCKS_ACROSS) : 1
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              queue_empty,
  input  bmp_item_t         head_item,
  input  logic [SLOT_W-1:0] head_slot,
  output logic              pop,
  output logic              res_valid,
  input  logic              res_ready,
  output bmp_result_t       result
);

  localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(SUM_W - 1);

  bmp_back_state_t   state;
  bmp_back_state_t   state_next;
  bmp_item_t         cur;
  logic [SLOT_W-1:0] cur_slot;
  bmp_acc_t          rd_acc;
  bmp_acc_t          acc_next;
  logic              ram_we;

  // Four restoring division lanes sharing one divisor.
  logic [SUM_W-1:0]   quo [4];
  logic [TALLY_W-1:0] rem [4];
  logic [SUM_W-1:0]   quo_next [4];
  logic [TALLY_W-1:0] rem_next [4];
  logic [TALLY_W-1:0] divisor;
  logic [STEP_W-1:0]  step;
  logic               load_out;

  bmp_ram #(
    .WIDTH ($bits(bmp_acc_t)),
    .DEPTH (MAX_BLOCKS_ACROSS)
  ) u_acc_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (cur_slot),
    .wdata (acc_next),
    .re    (pop),
    .raddr (head_slot),
    .rdata (rd_acc)
  );

  // A block's first pixel overwrites the slot; later pixels add into it.
  always_comb begin
    if (cur.first) begin
      acc_next.red   = SUM_W'(cur.red);
      acc_next.green = SUM_W'(cur.green);
      acc_next.blue  = SUM_W'(cur.blue);
      acc_next.alpha = SUM_W'(cur.alpha);
      acc_next.tally = TALLY_W'(1);
    end else begin
      acc_next.red   = rd_acc.red + SUM_W'(cur.red);
      acc_next.green = rd_acc.green + SUM_W'(cur.green);
      acc_next.blue  = rd_acc.blue + SUM_W'(cur.blue);
      acc_next.alpha = rd_acc.alpha + SUM_W'(cur.alpha);
      acc_next.tally = rd_acc.tally + 1'b1;
    end
  end

  always_comb begin
    logic [TALLY_W:0] trial;
    logic             fits;
    for (int i = 0; i < 4; i++) begin
      trial       = {rem[i], quo[i][SUM_W-1]};
      fits        = (trial >= {1'b0, divisor});
      rem_next[i] = fits ? TALLY_W'(trial - {1'b0, divisor}) : trial[TALLY_W-1:0];
      quo_next[i] = {quo[i][SUM_W-2:0], fits};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= BK_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    pop        = 1'b0;
    ram_we     = 1'b0;
    load_out   = 1'b0;
    unique case (state)
      BK_IDLE: begin
        if (!queue_empty) begin
          pop        = 1'b1;
          state_next = BK_ACC;
        end
      end
      BK_ACC: begin
        ram_we     = 1'b1;
        state_next = cur.last ? BK_DIV : BK_IDLE;
      end
      BK_DIV: begin
        if (step == LAST_STEP) begin
          state_next = BK_DONE;
        end
      end
      BK_DONE: begin
        if (!res_valid || res_ready) begin
          load_out   = 1'b1;
          state_next = BK_IDLE;
        end
      end
      default: state_next = BK_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      cur      <= head_item;
      cur_slot <= head_slot;
    end
    if (state == BK_ACC && cur.last) begin
      quo[0]  <= acc_next.red;
      quo[1]  <= acc_next.green;
      quo[2]  <= acc_next.blue;
      quo[3]  <= acc_next.alpha;
      for (int i = 0; i < 4; i++) begin
        rem[i] <= '0;
      end
      divisor <= acc_next.tally;
      step    <= '0;
    end else if (state == BK_DIV) begin
      for (int i = 0; i < 4; i++) begin
        quo[i] <= quo_next[i];
        rem[i] <= rem_next[i];
      end
      step <= step + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (load_out) begin
      res_valid <= 1'b1;
    end else if (res_ready) begin
      res_valid <= 1'b0;
    end
  end

  // A zero count cannot follow an add, but all means read zero if it does.
  always_ff @(posedge clk) begin
    if (load_out) begin
      result.block_col   <= cur.col;
      result.block_row   <= cur.row;
      result.mean_red    <= (divisor == '0) ? '0 : quo[0][CHAN_W-1:0];
      result.mean_green  <= (divisor == '0) ? '0 : quo[1][CHAN_W-1:0];
      result.mean_blue   <= (divisor == '0) ? '0 : quo[2][CHAN_W-1:0];
      result.mean_alpha  <= (divisor == '0) ? '0 : quo[3][CHAN_W-1:0];
      result.clip_width  <= cur.cw;
      result.clip_height <= cur.ch;
    end
  end

  `BMP_ASSERT_IMPLY(a_div_step_range, state == BK_DIV, step <= LAST_STEP, "division step out of range")
  `BMP_ASSERT_NEXT(a_last_goes_div, state == BK_ACC && cur.last, state == BK_DIV, "block end did not start division")
  `BMP_ASSERT_IMPLY(a_result_from_done, $rose(res_valid), $past(state) == BK_DONE, "result raised outside completion")

endmodule

/* rtl/block_mean_pixelate.sv */
`timescale 1ns / 1ps
// Mosaic pixelation by block averaging: RGBA pixels enter in raster order on the
// slave stream, one per transaction, and the frame is tiled into square blocks
// of block_size pixels, clipped at the right and bottom edges. When the
// bottom-right pixel of a block arrives, one transaction on the master stream
// carries the block's grid coordinates, the truncated mean of each channel and
// the clipped block size. The front end takes one pixel per cycle into a
// four-entry queue while the queue is not full; the accumulator behind it
// handles one pixel at a time by a read-modify-write of the block-column
// accumulator memory (registered read then write back), and a block-closing
// pixel also waits for the four means from four 20-step restoring division
// lanes sharing one divisor. The accumulator memory has no reset: every block
// overwrites its slot with its first pixel. Any write to a listed configuration
// register restarts the frame at the top-left pixel; write configuration only
// while the block is idle.

module block_mean_pixelate
  import bmp_pkg::*;
#(
  parameter int unsigned MAX_BLOCKS_ACROSS = MAX_BLOCKS_ACROSS_DEF,
  parameter int unsigned MAX_BLOCK_SIDE    = MAX_BLOCK_SIDE_DEF
) (
  input  logic                   clk,
  input  logic                   rst,
  // Configuration writes: 0 frame_width, 1 frame_height, 2 block_size.
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [CFG_IDX_W-1:0]   cfg_index,
  input  logic [CFG_DAT_W-1:0]   cfg_data,
  // Pixel stream.
  input  logic                   s_tvalid,
  output logic                   s_tready,
  // s_tdata from bit 0: red_in, green_in, blue_in, alpha_in.
  input  logic [IN_TDATA_W-1:0]  s_tdata,
  // Block result stream.
  output logic                   m_tvalid,
  input  logic                   m_tready,
  // m_tdata from bit 0: block_col, block_row, mean_red, mean_green, mean_blue,
  // mean_alpha, clip_width, clip_height, then two zero bits.
  output logic [OUT_TDATA_W-1:0] m_tdata
);

  localparam int unsigned SLOT_W = (MAX_BLOCKS_ACROSS > 1) ? $clog2(MAX_BLOCKS_ACROSS) : 1;
  localparam int unsigned QWORD_W = $bits(bmp_item_t) + SLOT_W;

  logic              push;
  bmp_item_t         push_item;
  logic [SLOT_W-1:0] push_slot;
  logic              queue_full;
  logic              queue_empty;
  logic              pop;
  logic [QWORD_W-1:0] head_word;
  bmp_item_t         head_item;
  logic [SLOT_W-1:0] head_slot;
  bmp_result_t       result;

  // The front end owns the configuration registers and the raster position
  // counters. It tags each pixel with its block column and row, the clipped
  // block size, whether it opens or closes its block, and its memory slot.
  bmp_front #(
    .MAX_BLOCKS_ACROSS (MAX_BLOCKS_ACROSS),
    .MAX_BLOCK_SIDE    (MAX_BLOCK_SIDE)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .pix_valid  (s_tvalid),
    .pix_red    (s_tdata[7:0]),
    .pix_green  (s_tdata[15:8]),
    .pix_blue   (s_tdata[23:16]),
    .pix_alpha  (s_tdata[31:24]),
    .queue_full (queue_full),
    .pix_ready  (s_tready),
    .push       (push),
    .push_item  (push_item),
    .push_slot  (push_slot)
  );

  // The queue decouples the pixel stream from the accumulator, so a stalled
  // result does not stop pixels from being taken until the queue fills.
  bmp_fifo #(
    .WIDTH (QWORD_W),
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data ({push_slot, push_item}),
    .pop       (pop),
    .head      (head_word),
    .full      (queue_full),
    .empty     (queue_empty)
  );

  assign head_item = head_word[$bits(bmp_item_t)-1:0];
  assign head_slot = head_word[QWORD_W-1:$bits(bmp_item_t)];

  // The back end accumulates into the per-column memory, divides at the end
  // of each block and holds the result in its output register.
  bmp_back #(
    .MAX_BLOCKS_ACROSS (MAX_BLOCKS_ACROSS)
  ) u_back (
    .clk         (clk),
    .rst         (rst),
    .queue_empty (queue_empty),
    .head_item   (head_item),
    .head_slot   (head_slot),
    .pop         (pop),
    .res_valid   (m_tvalid),
    .res_ready   (m_tready),
    .result      (result)
  );

  // Pack the result with the first field in the lowest bits.
  assign m_tdata = {2'b00, result.clip_height, result.clip_width, result.mean_alpha,
                    result.mean_blue, result.mean_green, result.mean_red,
                    result.block_row, result.block_col};

endmodule
